FILE: design/mra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mra_pkg
// Shared types and constants of the mouse report accelerator.
// ----------------------------------------------------------------------------
package mra_pkg;

    localparam int ACC_W   = 12;
    localparam int MAG_W   = 8;
    localparam int SUM_W   = 9;
    localparam int AXIS_W  = 8;
    localparam int BTN_W   = 3;
    localparam int TGT_W   = 3;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic [ACC_W-1:0]  ACC_MAX  = 12'hfff;
    localparam logic [AXIS_W-1:0] AXIS_POS = 8'sd127;
    localparam logic [AXIS_W-1:0] AXIS_NEG = 8'h81;   // -127

    localparam logic [TGT_W-1:0] TGT_X     = 3'd0;
    localparam logic [TGT_W-1:0] TGT_Y     = 3'd1;
    localparam logic [TGT_W-1:0] TGT_WHEEL = 3'd2;
    localparam logic [TGT_W-1:0] TGT_BTN1  = 3'd3;
    localparam logic [TGT_W-1:0] TGT_BTN2  = 3'd4;
    localparam logic [TGT_W-1:0] TGT_BTN3  = 3'd5;

    localparam logic [BTN_W-1:0] BTN1_BIT = 3'b100;
    localparam logic [BTN_W-1:0] BTN2_BIT = 3'b010;
    localparam logic [BTN_W-1:0] BTN3_BIT = 3'b001;

    localparam logic REG_POS_STEP   = 1'b0;
    localparam logic REG_WHEEL_STEP = 1'b1;

    localparam logic [ACC_W-1:0] STEP_RESET = 12'd4;

    // classified definition as it sits in the queue
    typedef struct packed {
        logic              entry_valid;
        logic              sel_x;
        logic              sel_y;
        logic              sel_wheel;
        logic [BTN_W-1:0]  btn;
        logic              negative;
        logic [MAG_W-1:0]  magnitude;
        logic              use_accel;
        logic              frame_end;
        logic              timer_frame;
    } t_cls;

    typedef struct packed {
        logic [ACC_W-1:0] pos_step;
        logic [ACC_W-1:0] wheel_step;
    } t_steps;

    typedef struct packed {
        logic push;
    } t_qwr;

    typedef struct packed {
        logic valid;
    } t_qrd;

endpackage

FILE: design/mra_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mra_item_if
// Input channel: one mouse definition or frame marker per beat.
// ----------------------------------------------------------------------------
interface mra_item_if
    import mra_pkg::*;
    ;
    logic             valid;
    logic             ready;
    logic             entry_valid;
    logic [TGT_W-1:0] target;
    logic             negative;
    logic [MAG_W-1:0] magnitude;
    logic             use_accel;
    logic             frame_end;
    logic             timer_frame;

    modport source (
        output valid, entry_valid, target, negative, magnitude, use_accel,
               frame_end, timer_frame,
        input  ready
    );
    modport sink (
        input  valid, entry_valid, target, negative, magnitude, use_accel,
               frame_end, timer_frame,
        output ready
    );
endinterface

FILE: design/mra_report_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mra_report_if
// Output channel: one mouse report per beat.
// ----------------------------------------------------------------------------
interface mra_report_if
    import mra_pkg::*;
    ;
    logic                     valid;
    logic                     ready;
    logic signed [AXIS_W-1:0] move_x;
    logic signed [AXIS_W-1:0] move_y;
    logic signed [AXIS_W-1:0] scroll;
    logic        [BTN_W-1:0]  button_bits;
    logic                     any_active;

    modport source (
        output valid, move_x, move_y, scroll, button_bits, any_active,
        input  ready
    );
    modport sink (
        input  valid, move_x, move_y, scroll, button_bits, any_active,
        output ready
    );
endinterface

FILE: design/mra_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mra_front
// Accepts input beats and decodes the target into per-field selects.
// ----------------------------------------------------------------------------
module mra_front
    import mra_pkg::*;
(
    mra_item_if.sink  i_item,
    input  logic      i_q_full,
    output t_qwr      o_qwr,
    output t_cls      o_cls
);

    logic w_sel_x;
    logic w_sel_y;
    logic w_sel_wheel;
    logic [BTN_W-1:0] w_btn;

    always_comb begin
        w_sel_x     = 1'b0;
        w_sel_y     = 1'b0;
        w_sel_wheel = 1'b0;
        w_btn       = '0;
        unique case (i_item.target)
            TGT_X:     w_sel_x     = 1'b1;
            TGT_Y:     w_sel_y     = 1'b1;
            TGT_WHEEL: w_sel_wheel = 1'b1;
            TGT_BTN1:  w_btn       = BTN1_BIT;
            TGT_BTN2:  w_btn       = BTN2_BIT;
            TGT_BTN3:  w_btn       = BTN3_BIT;
            default: ;  // counts as seen only
        endcase
    end

    assign i_item.ready = !i_q_full;
    assign o_qwr.push   = i_item.valid && !i_q_full;

    assign o_cls.entry_valid = i_item.entry_valid;
    assign o_cls.sel_x       = w_sel_x;
    assign o_cls.sel_y       = w_sel_y;
    assign o_cls.sel_wheel   = w_sel_wheel;
    assign o_cls.btn         = w_btn;
    assign o_cls.negative    = i_item.negative;
    assign o_cls.magnitude   = i_item.magnitude;
    assign o_cls.use_accel   = i_item.use_accel;
    assign o_cls.frame_end   = i_item.frame_end;
    assign o_cls.timer_frame = i_item.timer_frame;

endmodule

FILE: design/mra_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mra_queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module mra_queue
    import mra_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_cls,
    input  logic i_pop,
    output logic o_full,
    output t_qrd o_rd_valid,
    output t_cls o_cls
);

    t_cls            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_AW:0]   r_count;

    logic w_pop;

    assign o_full           = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign w_pop            = i_pop && (r_count != '0);
    assign o_rd_valid.valid = (r_count != '0);
    assign o_cls            = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: design/mra_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mra_back
// Scales displacements, collects the frame and emits reports; steps or
// clears the accelerators on timer frames.
// ----------------------------------------------------------------------------
module mra_back
    import mra_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_steps        i_steps,
    input  logic          i_head_valid,
    input  t_cls          i_head,
    output logic          o_pop,
    mra_report_if.source  o_report
);

    logic [ACC_W-1:0] r_pos_acc, n_pos_acc;
    logic [ACC_W-1:0] r_wheel_acc, n_wheel_acc;
    logic signed [SUM_W-1:0] r_sum_x, n_sum_x;
    logic signed [SUM_W-1:0] r_sum_y, n_sum_y;
    logic signed [SUM_W-1:0] r_sum_w, n_sum_w;
    logic [BTN_W-1:0] r_btn, n_btn;
    logic             r_seen, n_seen;

    logic                     r_out_valid;
    logic signed [AXIS_W-1:0] r_out_x, r_out_y, r_out_w;
    logic        [BTN_W-1:0]  r_out_btn;
    logic                     r_out_any;

    logic [ACC_W-1:0]         w_acc;
    logic [ACC_W:0]           w_lim;
    logic [MAG_W+ACC_W-1:0]   w_prod;
    logic [MAG_W:0]           w_dacc;
    logic [MAG_W-1:0]         w_d;
    logic signed [SUM_W-1:0]  w_sd;
    logic signed [AXIS_W-1:0] w_rx, w_ry, w_rw;
    logic                     w_emit;

    function automatic logic signed [AXIS_W-1:0] clamp_axis(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [AXIS_W-1:0] res;
        if (v > $signed(SUM_W'(AXIS_POS))) begin
            res = AXIS_POS;
        end else if (v < -$signed(SUM_W'(AXIS_POS))) begin
            res = AXIS_NEG;
        end else begin
            res = v[AXIS_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [ACC_W-1:0] step_acc(
        input logic [ACC_W-1:0] acc,
        input logic [ACC_W-1:0] step
    );
        logic [ACC_W:0] s;
        s = {1'b0, acc} + {1'b0, step};
        return (s > {1'b0, ACC_MAX}) ? ACC_MAX : s[ACC_W-1:0];
    endfunction

    assign o_pop  = i_head_valid && (!i_head.frame_end || !r_out_valid || o_report.ready);
    assign w_emit = o_pop && i_head.frame_end;

    // displacement
    always_comb begin
        w_acc  = i_head.sel_wheel ? r_wheel_acc : r_pos_acc;
        w_lim  = {1'b0, w_acc} + (ACC_W+1)'(i_head.magnitude);
        w_prod = (MAG_W+ACC_W)'(i_head.magnitude) * (MAG_W+ACC_W)'(w_acc);
        w_dacc = {1'b0, w_prod[MAG_W+ACC_W-1:ACC_W]} + 1'b1;
        w_d    = i_head.magnitude;
        if (i_head.use_accel && (w_lim < {1'b0, ACC_MAX})) begin
            if (w_dacc <= {1'b0, i_head.magnitude}) begin
                w_d = w_dacc[MAG_W-1:0];
            end
        end
        if (w_d == '0) begin
            w_d = MAG_W'(1);
        end
        w_sd = i_head.negative ? -$signed({1'b0, w_d}) : $signed({1'b0, w_d});
    end

    // frame collection
    always_comb begin
        n_sum_x = r_sum_x;
        n_sum_y = r_sum_y;
        n_sum_w = r_sum_w;
        n_btn   = r_btn;
        n_seen  = r_seen;
        if (i_head.entry_valid) begin
            n_seen = 1'b1;
            n_btn  = r_btn | i_head.btn;
            if (i_head.sel_x && r_sum_x == '0) begin
                n_sum_x = w_sd;
            end
            if (i_head.sel_y && r_sum_y == '0) begin
                n_sum_y = w_sd;
            end
            if (i_head.sel_wheel && r_sum_w == '0) begin
                n_sum_w = w_sd;
            end
        end
        w_rx = clamp_axis(n_sum_x);
        w_ry = clamp_axis(n_sum_y);
        w_rw = clamp_axis(n_sum_w);

        n_pos_acc   = r_pos_acc;
        n_wheel_acc = r_wheel_acc;
        if (i_head.timer_frame) begin
            if (!n_seen) begin
                n_pos_acc   = '0;
                n_wheel_acc = '0;
            end else begin
                n_pos_acc   = (w_rx != '0 || w_ry != '0)
                              ? step_acc(r_pos_acc, i_steps.pos_step) : '0;
                n_wheel_acc = (w_rw != '0)
                              ? step_acc(r_wheel_acc, i_steps.wheel_step) : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_acc   <= '0;
            r_wheel_acc <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_w     <= '0;
            r_btn       <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_report.valid && o_report.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_pos_acc   <= n_pos_acc;
                r_wheel_acc <= n_wheel_acc;
                r_sum_x     <= '0;
                r_sum_y     <= '0;
                r_sum_w     <= '0;
                r_btn       <= '0;
                r_seen      <= 1'b0;
            end else if (o_pop) begin
                r_sum_x     <= n_sum_x;
                r_sum_y     <= n_sum_y;
                r_sum_w     <= n_sum_w;
                r_btn       <= n_btn;
                r_seen      <= n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_x   <= w_rx;
            r_out_y   <= w_ry;
            r_out_w   <= w_rw;
            r_out_btn <= n_btn;
            r_out_any <= n_seen;
        end
    end

    assign o_report.valid       = r_out_valid;
    assign o_report.move_x      = r_out_x;
    assign o_report.move_y      = r_out_y;
    assign o_report.scroll      = r_out_w;
    assign o_report.button_bits = r_out_btn;
    assign o_report.any_active  = r_out_any;

endmodule

FILE: design/mouse_report_accelerator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mouse_report_accelerator
// Builds one mouse report per frame from a stream of mouse definitions.
//
// i_item takes one beat per cycle while ready: a definition or an empty frame marker.
// The beat with frame_end closes the frame; in the cycle after it leaves the
// queue, its report appears on o_report and is held until taken.
// The front decodes each beat into a four-entry queue; the back drains one entry
// per cycle unless o_report stalls, so throughput is one beat per cycle. The
// closing beat is written to the queue, then popped as its report is registered.
// While o_report stalls, the back stops at the next closing beat and the
// queue fills; i_item.ready drops when it is full.
// Registers (APB, byte address 4*i): 0 pos_accel_step, 1 wheel_accel_step,
// both 4 after reset. Reset clears the queue, sums and accelerators.
// ----------------------------------------------------------------------------
module mouse_report_accelerator
    import mra_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    mra_item_if.sink          i_item,
    mra_report_if.source      o_report
);

    t_steps r_steps;
    t_qwr   w_qwr;
    t_qrd   w_qrd;
    t_cls   w_push_cls;
    t_cls   w_head;
    logic   w_full;
    logic   w_pop;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps.pos_step   <= STEP_RESET;
            r_steps.wheel_step <= STEP_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_POS_STEP:   r_steps.pos_step   <= pwdata[ACC_W-1:0];
                REG_WHEEL_STEP: r_steps.wheel_step <= pwdata[ACC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_POS_STEP:   prdata = APB_DW'(r_steps.pos_step);
            REG_WHEEL_STEP: prdata = APB_DW'(r_steps.wheel_step);
            default:        prdata = '0;
        endcase
    end

    mra_front u_front (
        .i_item   (i_item),
        .i_q_full (w_full),
        .o_qwr    (w_qwr),
        .o_cls    (w_push_cls)
    );

    mra_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_qwr.push),
        .i_cls      (w_push_cls),
        .i_pop      (w_pop),
        .o_full     (w_full),
        .o_rd_valid (w_qrd),
        .o_cls      (w_head)
    );

    mra_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_steps      (r_steps),
        .i_head_valid (w_qrd.valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_report     (o_report)
    );

endmodule
